[src/cic_mass_deposit_core_defines.svh]
// assertion macros for the cloud-in-cell deposit core
// expects clk and rst_n in the scope of use
`ifndef CIC_MASS_DEPOSIT_CORE_DEFINES_SVH
`define CIC_MASS_DEPOSIT_CORE_DEFINES_SVH

// same-cycle implication
`define CMD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CMD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/cmd_pkg.sv]
// shared constants for the cloud-in-cell deposit core
// no dependencies
`timescale 1ns / 1ps

package cmd_pkg;

  localparam int LOG2_MESH_DEF = 5;
  localparam int ACC_W         = 40;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int POS_W         = 32;
  localparam int FRAC_W        = 16;
  localparam int CELL_IDX_W    = 15;

  // Q1.16 one, and the Q24.16 reset value and saturation bound
  localparam logic [FRAC_W:0]  ONE_Q16   = 17'h10000;
  localparam logic [ACC_W-1:0] MINUS_ONE = 40'hFFFFFF0000;
  localparam logic [ACC_W-1:0] ACC_MAX   = 40'h7FFFFFFFFF;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_SCALE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTICLE_WEIGHT = 2'd1;

  localparam logic [CFG_W-1:0] GRID_SCALE_RST      = 32'h0100_0000;
  localparam logic [CFG_W-1:0] PARTICLE_WEIGHT_RST = 32'h0001_0000;

  localparam logic OP_DEPOSIT = 1'b0;
  localparam logic OP_READ    = 1'b1;

endpackage

[src/cic_mass_deposit_core.sv]
// cloud-in-cell mass deposit onto a periodic cubic density grid
// depends on cmd_pkg and cic_mass_deposit_core_defines.svh
`timescale 1ns / 1ps

// Keeps a MESH^3 grid (MESH = 2^LOG2_MESH) of signed Q24.16 accumulators in one
// single-port-style synchronous memory. After reset the block sweeps the memory
// to minus one, one cell per cycle, and busy stays high until the sweep is
// through, so no beat is taken before then; config writes are taken at any
// time. A deposit beat first scales the three axes through the shared
// multiplier, then works through the eight corners in turn (three multiplies
// for the weight, one memory read, one add and write back). The shared 33x32
// multiplier and the read-modify-write on the single memory port keep busy
// high until a beat is through, so no new beat is taken before then. A read
// beat reads the cell into rdata_r on accept, then in S_RRD registers it into
// out_cell_value and raises out_strobe, and the cell is set back to minus one.
// The receiver cannot stall; a deposit gives no result.

module cic_mass_deposit_core #(
  parameter int LOG2_MESH = cmd_pkg::LOG2_MESH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_op,
  input  logic [cmd_pkg::POS_W-1:0]            in_pos_x,
  input  logic [cmd_pkg::POS_W-1:0]            in_pos_y,
  input  logic [cmd_pkg::POS_W-1:0]            in_pos_z,
  input  logic [cmd_pkg::CELL_IDX_W-1:0]       in_cell_index,
  // result channel
  output logic                                 out_strobe,
  output logic signed [cmd_pkg::ACC_W-1:0]     out_cell_value,
  output logic                                 out_overflow_seen,
  // config write port
  input  logic                                 cfg_we,
  input  logic [cmd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [cmd_pkg::CFG_W-1:0]            cfg_wdata
);

  import cmd_pkg::*;

  `include "cic_mass_deposit_core_defines.svh"

  localparam int CELL_W = 3 * LOG2_MESH;
  localparam logic [2:0] CORNER_LAST = 3'b111;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MX, S_MY, S_MZ, S_CAP,
    S_W1, S_W2, S_W3, S_RD, S_WR, S_RRD
  } state_t;

  state_t state_r;

  // config registers
  logic [CFG_W-1:0] grid_scale_r;
  logic [CFG_W-1:0] particle_weight_r;

  // latched beat and per-axis split
  logic [POS_W-1:0]     pos_y_r, pos_z_r;
  logic [LOG2_MESH-1:0] ix_r, iy_r, iz_r;
  logic [FRAC_W-1:0]    dx_r, dy_r, dz_r;
  logic [2:0]           corner_r;
  logic [CELL_W-1:0]    addr_r;
  logic [CELL_W-1:0]    clr_cnt_r;
  logic [32:0]          inc_r;
  logic                 sticky_r;

  // shared multiplier, product registered
  logic [32:0] mul_a;
  logic [31:0] mul_b;
  logic [64:0] prod_r;

  // grid memory
  logic [ACC_W-1:0] grid_mem [2**CELL_W];
  logic [ACC_W-1:0] rdata_r;
  logic             rd_en, wr_en;
  logic [CELL_W-1:0] rd_addr, wr_addr;
  logic [ACC_W-1:0] wr_data;

  // corner factors and address
  logic [FRAC_W:0]      tx, ty, tz, fa, fb, fc;
  logic [LOG2_MESH-1:0] nx, ny, nz, cx, cy, cz;
  logic [CELL_W-1:0]    corner_addr;
  logic [ACC_W:0]       sum;
  logic                 sat;
  logic                 accept;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    tx = ONE_Q16 - {1'b0, dx_r};
    ty = ONE_Q16 - {1'b0, dy_r};
    tz = ONE_Q16 - {1'b0, dz_r};
    fa = corner_r[2] ? {1'b0, dx_r} : tx;
    fb = corner_r[1] ? {1'b0, dy_r} : ty;
    fc = corner_r[0] ? {1'b0, dz_r} : tz;
    nx = ix_r + 1'b1;
    ny = iy_r + 1'b1;
    nz = iz_r + 1'b1;
    cx = corner_r[2] ? nx : ix_r;
    cy = corner_r[1] ? ny : iy_r;
    cz = corner_r[0] ? nz : iz_r;
    corner_addr = {cx, cy, cz};
  end

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_IDLE: begin
        mul_a = {1'b0, in_pos_x};
        mul_b = grid_scale_r;
      end
      S_MX: begin
        mul_a = {1'b0, pos_y_r};
        mul_b = grid_scale_r;
      end
      S_MY: begin
        mul_a = {1'b0, pos_z_r};
        mul_b = grid_scale_r;
      end
      S_W1: begin
        mul_a = {16'b0, fa};
        mul_b = {15'b0, fb};
      end
      S_W2: begin
        mul_a = prod_r[32:0];
        mul_b = {15'b0, fc};
      end
      S_W3: begin
        mul_a = {16'b0, prod_r[48:32]};
        mul_b = particle_weight_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // accumulate with saturation; increments are never negative
  always_comb begin
    sum = {rdata_r[ACC_W-1], rdata_r} + {8'b0, inc_r};
    sat = !sum[ACC_W] && sum[ACC_W-1];
  end

  // memory port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = corner_addr;
    wr_en   = 1'b0;
    wr_addr = addr_r;
    wr_data = MINUS_ONE;
    case (state_r)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_cnt_r;
      end
      S_IDLE: begin
        rd_en   = accept && (in_op == OP_READ);
        rd_addr = CELL_W'(in_cell_index);
      end
      S_RD: rd_en = 1'b1;
      S_WR: begin
        wr_en   = 1'b1;
        wr_data = sat ? ACC_MAX : sum[ACC_W-1:0];
      end
      S_RRD: wr_en = 1'b1;
      default: begin
        rd_en = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= grid_mem[rd_addr];
    end
  end

  // config writes; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_scale_r      <= GRID_SCALE_RST;
      particle_weight_r <= PARTICLE_WEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GRID_SCALE:      grid_scale_r <= cfg_wdata;
        REG_PARTICLE_WEIGHT: particle_weight_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_cnt_r  <= '0;
      sticky_r   <= 1'b0;
      out_strobe <= 1'b0;
      corner_r   <= '0;
    end else begin
      out_strobe <= 1'b0;
      prod_r     <= mul_a * mul_b;
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == '1) state_r <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            pos_y_r <= in_pos_y;
            pos_z_r <= in_pos_z;
            addr_r  <= CELL_W'(in_cell_index);
            state_r <= (in_op == OP_READ) ? S_RRD : S_MX;
          end
        end
        // m = pos * scale in Q24.40: cell above bit 40, fraction bits 39..24
        // each product is registered, so it lands in the cycle after its operands are selected
        S_MX: begin
          ix_r    <= prod_r[40 +: LOG2_MESH];
          dx_r    <= prod_r[39:24];
          state_r <= S_MY;
        end
        S_MY: begin
          iy_r    <= prod_r[40 +: LOG2_MESH];
          dy_r    <= prod_r[39:24];
          state_r <= S_MZ;
        end
        S_MZ: begin
          iz_r    <= prod_r[40 +: LOG2_MESH];
          dz_r    <= prod_r[39:24];
          state_r <= S_CAP;
        end
        S_CAP: begin
          corner_r <= '0;
          state_r  <= S_W1;
        end
        S_W1: state_r <= S_W2;
        S_W2: state_r <= S_W3;
        S_W3: state_r <= S_RD;
        S_RD: begin
          inc_r   <= prod_r[48:16];
          addr_r  <= corner_addr;
          state_r <= S_WR;
        end
        S_WR: begin
          if (sat) sticky_r <= 1'b1;
          corner_r <= corner_r + 1'b1;
          state_r  <= (corner_r == CORNER_LAST) ? S_IDLE : S_W1;
        end
        S_RRD: begin
          out_strobe        <= 1'b1;
          out_cell_value    <= rdata_r;
          out_overflow_seen <= sticky_r;
          state_r           <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CMD_ASSERT_NOW(a_strobe_after_read, out_strobe, $past(state_r == S_RRD), "strobe without read")
  `CMD_ASSERT_NEXT(a_sticky_holds, sticky_r, sticky_r, "overflow flag cleared")
  `CMD_ASSERT_NEXT(a_last_corner_done, (state_r == S_WR) && (corner_r == CORNER_LAST), !busy, "deposit did not finish")

endmodule
